// ===== src/indexed_min_heap_queue_unit_macros.svh =====
// Assertion helpers for the heap queue unit.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define IMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never occur outside reset.
`define IMHQ_NEVER(label, cond, msg) \
  `IMHQ_ASSERT(label, !(cond), msg)

`endif

// ===== src/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and codes for the indexed min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

  localparam int ID_W   = 9;
  localparam int PRIO_W = 32;
  localparam int STAT_W = 3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [1:0]               command;
    logic [ID_W-1:0]          elem_id;
    logic signed [PRIO_W-1:0] new_priority;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          entry_count;
    logic                     is_empty;
    logic [ID_W-1:0]          top_id;
    logic signed [PRIO_W-1:0] top_priority;
    logic                     elem_present;
    logic signed [PRIO_W-1:0] elem_priority;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== src/indexed_min_heap_queue_unit.sv =====
// A query or a rejected request passes from S_LOOK through S_TOP_RD, S_EL_RD and
// S_FIN to S_DONE; an accepted insert, update or remove may first move an entry, with
// S_UP_RD and S_UP_CMP per level of an upward sift and S_DN_RDL to S_DN_CMP downward.
// Only one request is in flight; the next is taken after the response is registered.
// After reset all min(CAPACITY,511)+1 entries of the position map are cleared,
// one entry a cycle, before the first request is taken.
`default_nettype none
`include "indexed_min_heap_queue_unit_macros.svh"

module indexed_min_heap_queue_unit #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire imhq_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output imhq_pkg::out_rsp_t      out_data
);

  localparam int IW        = imhq_pkg::ID_W;
  localparam int PW        = imhq_pkg::PRIO_W;
  localparam int SA        = $clog2(CAPACITY);
  localparam int SW        = $clog2(CAPACITY + 1);
  localparam int MAP_DEPTH = ((CAPACITY < 511) ? CAPACITY : 511) + 1;
  localparam int MA        = $clog2(MAP_DEPTH);
  localparam int HW        = IW + KEY_WIDTH;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_LOOK   = 15'b000000000000100,
    S_RM1    = 15'b000000000001000,
    S_RM2    = 15'b000000000010000,
    S_UPD    = 15'b000000000100000,
    S_UP_RD  = 15'b000000001000000,
    S_UP_CMP = 15'b000000010000000,
    S_DN_RDL = 15'b000000100000000,
    S_DN_RDR = 15'b000001000000000,
    S_DN_CMP = 15'b000010000000000,
    S_TOP_RD = 15'b000100000000000,
    S_EL_RD  = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Heap memory (slot s at address s-1) and id-to-slot map.
  logic [HW-1:0] heap_mem [CAPACITY];
  logic [SW-1:0] map_mem  [MAP_DEPTH];

  logic [HW-1:0] heap_rdata_r;
  logic [SW-1:0] map_rdata_r;
  logic [SA-1:0] heap_raddr, heap_waddr;
  logic [HW-1:0] heap_wdata;
  logic          heap_we;
  logic [MA-1:0] map_raddr, map_waddr;
  logic [SW-1:0] map_wdata;
  logic          map_we;

  logic [MA-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]                fill_r, fill_nxt;
  logic [SW-1:0]                pos_r, pos_nxt;
  logic [1:0]                   cmd_r, cmd_nxt;
  logic                         valid_r, valid_nxt;
  logic [IW-1:0]                req_id_r, req_id_nxt;
  logic [IW-1:0]                cur_id_r, cur_id_nxt;
  logic signed [KEY_WIDTH-1:0]  cur_key_r, cur_key_nxt;
  logic [HW-1:0]                left_r, left_nxt;
  logic                         has_r_r, has_r_nxt;
  logic [imhq_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [IW-1:0]                top_id_r, top_id_nxt;
  logic signed [KEY_WIDTH-1:0]  top_key_r, top_key_nxt;
  logic                         el_pres_r, el_pres_nxt;
  logic signed [KEY_WIDTH-1:0]  el_key_r, el_key_nxt;
  logic                         out_valid_r, out_valid_nxt;
  imhq_pkg::out_rsp_t           out_data_r, out_data_nxt;

  logic [SW:0]                  child_l, child_r;
  logic [SW-1:0]                parent;
  logic [IW-1:0]                rd_id;
  logic signed [KEY_WIDTH-1:0]  rd_key, left_key, pick_key;
  logic [HW-1:0]                cur_word, pick;
  logic                         pick_right;
  logic                         in_valid_id;

  always_comb begin
    child_l     = {pos_r, 1'b0};
    child_r     = child_l + (SW+1)'(1);
    parent      = pos_r >> 1;
    rd_id       = heap_rdata_r[HW-1 -: IW];
    rd_key      = heap_rdata_r[KEY_WIDTH-1:0];
    left_key    = left_r[KEY_WIDTH-1:0];
    cur_word    = {cur_id_r, cur_key_r};
    pick_right  = has_r_r && (rd_key < left_key);
    pick        = pick_right ? heap_rdata_r : left_r;
    pick_key    = pick[KEY_WIDTH-1:0];
    in_valid_id = (32'(in_data.elem_id) <= 32'(CAPACITY));
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r;
    req_id_nxt    = req_id_r;
    cur_id_nxt    = cur_id_r;
    cur_key_nxt   = cur_key_r;
    left_nxt      = left_r;
    has_r_nxt     = has_r_r;
    status_nxt    = status_r;
    top_id_nxt    = top_id_r;
    top_key_nxt   = top_key_r;
    el_pres_nxt   = el_pres_r;
    el_key_nxt    = el_key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    heap_raddr    = '0;
    heap_we       = 1'b0;
    heap_waddr    = SA'(pos_r - SW'(1));
    heap_wdata    = cur_word;
    map_raddr     = MA'(cur_id_r);
    map_we        = 1'b0;
    map_waddr     = MA'(cur_id_r);
    map_wdata     = pos_r;
    in_ready      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_r;
        map_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + MA'(1);
        if (clr_cnt_r == MA'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        map_raddr = MA'(in_data.elem_id);
        if (in_valid) begin
          cmd_nxt     = in_data.command;
          valid_nxt   = in_valid_id;
          req_id_nxt  = in_data.elem_id;
          cur_id_nxt  = in_data.elem_id;
          cur_key_nxt = KEY_WIDTH'(in_data.new_priority);
          status_nxt  = imhq_pkg::ST_OK;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        heap_raddr = SA'(map_rdata_r - SW'(1));
        state_nxt  = S_TOP_RD;
        unique case (cmd_r)
          imhq_pkg::CMD_INSERT: begin
            if (!valid_r) begin
              status_nxt = imhq_pkg::ST_ABSENT;
            end else if (map_rdata_r != '0) begin
              status_nxt = imhq_pkg::ST_PRESENT;
            end else if (32'(fill_r) >= 32'(CAPACITY)) begin
              status_nxt = imhq_pkg::ST_FULL;
            end else begin
              fill_nxt  = fill_r + SW'(1);
              pos_nxt   = fill_r + SW'(1);
              state_nxt = S_UP_RD;
            end
          end
          imhq_pkg::CMD_REMOVE: begin
            if (fill_r == '0) begin
              status_nxt = imhq_pkg::ST_EMPTY;
            end else begin
              heap_raddr = '0;
              state_nxt  = S_RM1;
            end
          end
          imhq_pkg::CMD_UPDATE: begin
            if (!valid_r || map_rdata_r == '0) begin
              status_nxt = imhq_pkg::ST_ABSENT;
            end else begin
              pos_nxt   = map_rdata_r;
              state_nxt = S_UPD;
            end
          end
          default: begin
            state_nxt = S_TOP_RD;
          end
        endcase
      end
      S_RM1: begin
        // Root leaves the heap; fetch the last entry to refill the root.
        map_we     = 1'b1;
        map_waddr  = MA'(rd_id);
        map_wdata  = '0;
        heap_raddr = SA'(fill_r - SW'(1));
        state_nxt  = S_RM2;
      end
      S_RM2: begin
        fill_nxt = fill_r - SW'(1);
        if (fill_r == SW'(1)) begin
          state_nxt = S_TOP_RD;
        end else begin
          cur_id_nxt  = rd_id;
          cur_key_nxt = rd_key;
          pos_nxt     = SW'(1);
          state_nxt   = S_DN_RDL;
        end
      end
      S_UPD: begin
        if (cur_key_r < rd_key) begin
          state_nxt = S_UP_RD;
        end else if (rd_key < cur_key_r) begin
          state_nxt = S_DN_RDL;
        end else begin
          heap_we   = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_UP_RD: begin
        heap_raddr = SA'(parent - SW'(1));
        if (pos_r == SW'(1)) begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (cur_key_r < rd_key) begin
          // Parent moves down into the hole.
          heap_we    = 1'b1;
          heap_wdata = heap_rdata_r;
          map_we     = 1'b1;
          map_waddr  = MA'(rd_id);
          pos_nxt    = parent;
          state_nxt  = S_UP_RD;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_DN_RDL: begin
        heap_raddr = SA'(child_l - (SW+1)'(1));
        if (child_l > {1'b0, fill_r}) begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        left_nxt   = heap_rdata_r;
        has_r_nxt  = (child_r <= {1'b0, fill_r});
        heap_raddr = SA'(child_r - (SW+1)'(1));
        state_nxt  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (pick_key < cur_key_r) begin
          heap_we    = 1'b1;
          heap_wdata = pick;
          map_we     = 1'b1;
          map_waddr  = MA'(pick[HW-1 -: IW]);
          pos_nxt    = pick_right ? SW'(child_r) : SW'(child_l);
          state_nxt  = S_DN_RDL;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        heap_raddr = '0;
        map_raddr  = MA'(req_id_r);
        state_nxt  = S_EL_RD;
      end
      S_EL_RD: begin
        top_id_nxt  = rd_id;
        top_key_nxt = rd_key;
        el_pres_nxt = valid_r && (map_rdata_r != '0);
        heap_raddr  = SA'(map_rdata_r - SW'(1));
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        el_key_nxt = rd_key;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.entry_count   = IW'(fill_r);
          out_data_nxt.is_empty      = (fill_r == '0);
          out_data_nxt.top_id        = (fill_r == '0) ? '0 : top_id_r;
          out_data_nxt.top_priority  = (fill_r == '0) ? '0 : PW'(top_key_r);
          out_data_nxt.elem_present  = el_pres_r;
          out_data_nxt.elem_priority = el_pres_r ? PW'(el_key_r) : '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    heap_rdata_r <= heap_mem[heap_raddr];
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    map_rdata_r <= map_mem[map_raddr];
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cmd_r      <= cmd_nxt;
    valid_r    <= valid_nxt;
    req_id_r   <= req_id_nxt;
    cur_id_r   <= cur_id_nxt;
    cur_key_r  <= cur_key_nxt;
    left_r     <= left_nxt;
    has_r_r    <= has_r_nxt;
    status_r   <= status_nxt;
    top_id_r   <= top_id_nxt;
    top_key_r  <= top_key_nxt;
    el_pres_r  <= el_pres_nxt;
    el_key_r   <= el_key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IMHQ_NEVER(a_fill_bound, 32'(fill_r) > 32'(CAPACITY), "fill count above capacity")
  `IMHQ_ASSERT(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `IMHQ_ASSERT(a_accept_moves, (in_valid && in_ready) |=> (state_r == S_LOOK), "request not taken")
  `IMHQ_NEVER(a_no_take_in_clear, (state_r == S_CLEAR) && in_ready, "request taken during map clear")

endmodule

`default_nettype wire
